// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ddo_pkg.sv =====
`timescale 1ns / 1ps

package ddo_pkg;

    // Field widths
    localparam int TICK_W     = 32;
    localparam int FACTOR_W   = 24;
    localparam int POS_W      = 48;
    localparam int HEAD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default build options
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int FRAC_BITS_DEF         = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MPT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MPT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEELBASE = 2'd2;

    // Configuration reset values
    localparam logic [FACTOR_W-1:0] LEFT_MPT_RST      = 24'd56921;
    localparam logic [FACTOR_W-1:0] RIGHT_MPT_RST     = 24'd59388;
    localparam logic [FACTOR_W-1:0] INV_WHEELBASE_RST = 24'd66873;

    // Factor and heading scaling
    localparam int FACTOR_FRAC = 24;
    localparam int IBW_FRAC    = 16;
    localparam int INC_SHIFT   = 30;

    // Angles in Q.30
    localparam longint ANG_PI       = 64'sd3373259426;
    localparam longint ANG_TWO_PI   = 64'sd6746518852;
    localparam longint ANG_HALF_PI  = 64'sd1686629713;
    localparam longint CORDIC_START = 64'sd652032874;

    // Shared multiplier widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Cosine and sine in Q.29
    localparam int TRIG_W = 32;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q29;
        logic signed [TRIG_W-1:0] sin_q29;
    } trig_t;

    // Arctangent of 2^-k in Q.30, rounded to nearest
    localparam int ATAN_W = 30;
    localparam logic [ATAN_W-1:0] ARCTAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

endpackage

// ===== hdl/ddo_if.sv =====
`timescale 1ns / 1ps

// Encoder count channel
interface ddo_ticks_if import ddo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TICK_W-1:0] left_ticks;
    logic signed [TICK_W-1:0] right_ticks;

    modport source (output valid, output left_ticks, output right_ticks, input ready);
    modport sink   (input valid, input left_ticks, input right_ticks, output ready);
endinterface

// Pose result channel
interface ddo_pose_if import ddo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

// Configuration write channel
interface ddo_cfg_if import ddo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ddo_mul.sv =====
`timescale 1ns / 1ps

module ddo_mul import ddo_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    // Register the full signed product
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== hdl/ddo_cordic.sv =====
`timescale 1ns / 1ps

module ddo_cordic import ddo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int FRAC_BITS         = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [HEAD_W-1:0] heading,
    output logic                     done,
    output trig_t                    trig
);

    localparam int ANG_W = HEAD_W + 30 - FRAC_BITS;
    localparam int RW    = ANG_W + 1;
    localparam int SHIFT = 30 - FRAC_BITS;
    localparam int CNT_W = $clog2(CORDIC_ITERATIONS);
    localparam int XY_W  = 34;
    localparam int ZW    = 35;
    localparam int LOW_W = 34;

    localparam logic [RW-1:0] MOD_LAST  = RW'(ANG_TWO_PI);
    localparam logic [RW-1:0] MOD_START = MOD_LAST << (ANG_W - 32);

    localparam logic signed [ZW-1:0]   PI_Z      = ZW'(ANG_PI);
    localparam logic signed [ZW-1:0]   TWO_PI_Z  = ZW'(ANG_TWO_PI);
    localparam logic signed [ZW-1:0]   HALF_PI_Z = ZW'(ANG_HALF_PI);
    localparam logic signed [XY_W-1:0] X_START   = XY_W'(CORDIC_START);
    localparam logic [CNT_W-1:0]       CNT_LAST  = CNT_W'(CORDIC_ITERATIONS - 1);

    typedef enum logic [2:0] {C_IDLE, C_RED, C_WRAP, C_FLIP, C_ITER, C_OUT} cstate_t;

    cstate_t    state_reg, state_next;
    logic       neg_reg;
    logic       flip_reg;
    logic       done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [RW-1:0]           r_reg;
    logic [RW-1:0]           m_reg;
    logic signed [ZW-1:0]    z_reg;
    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    trig_t                   trig_reg;

    logic [HEAD_W:0]         head_ext;
    logic [HEAD_W:0]         abs_h;
    logic [RW-1:0]           r_init;
    logic [RW-1:0]           r_red;
    logic signed [ZW-1:0]    r_low;
    logic signed [ZW-1:0]    z_wrap;
    logic                    z_gt;
    logic                    z_lt;
    logic [4:0]              k;
    logic signed [XY_W-1:0]  x_sh;
    logic signed [XY_W-1:0]  y_sh;
    logic signed [ZW-1:0]    atan;
    logic signed [XY_W-1:0]  x_half;
    logic signed [XY_W-1:0]  y_half;
    logic signed [TRIG_W-1:0] c_out;
    logic signed [TRIG_W-1:0] s_out;

    // Magnitude of the angle in Q.30
    always_comb
    begin
        head_ext = {heading[HEAD_W-1], heading};
        abs_h    = heading[HEAD_W-1] ? (~head_ext + 1'b1) : head_ext;
        r_init   = RW'(abs_h) << SHIFT;
    end

    // One restoring step of the reduction modulo two pi
    assign r_red = (r_reg >= m_reg) ? (r_reg - m_reg) : r_reg;

    // Restore the sign and fold into plus or minus pi
    always_comb
    begin
        r_low = signed'(ZW'(r_reg[LOW_W-1:0]));
        if (r_low > PI_Z)
        begin
            z_wrap = neg_reg ? (TWO_PI_Z - r_low) : (r_low - TWO_PI_Z);
        end
        else
        begin
            z_wrap = neg_reg ? -r_low : r_low;
        end
    end

    assign z_gt = z_reg > HALF_PI_Z;
    assign z_lt = z_reg < -HALF_PI_Z;

    // One rotation step
    always_comb
    begin
        k    = 5'(cnt_reg);
        x_sh = x_reg >>> k;
        y_sh = y_reg >>> k;
        atan = signed'(ZW'(ARCTAN_Q30[k]));
    end

    // Scale to Q.29 and undo the half-turn fold
    always_comb
    begin
        x_half = x_reg >>> 1;
        y_half = y_reg >>> 1;
        c_out  = flip_reg ? -TRIG_W'(x_half) : TRIG_W'(x_half);
        s_out  = flip_reg ? -TRIG_W'(y_half) : TRIG_W'(y_half);
    end

    // Sequence the phases
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (start) state_next = C_RED;
            C_RED:  if (m_reg == MOD_LAST) state_next = C_WRAP;
            C_WRAP: state_next = C_FLIP;
            C_FLIP: state_next = C_ITER;
            C_ITER: if (cnt_reg == CNT_LAST) state_next = C_OUT;
            C_OUT:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // Hold state and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            neg_reg   <= 1'b0;
            flip_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_OUT);
            if (state_reg == C_IDLE && start)
            begin
                neg_reg <= heading[HEAD_W-1];
            end
            if (state_reg == C_FLIP)
            begin
                flip_reg <= z_gt || z_lt;
                cnt_reg  <= '0;
            end
            if (state_reg == C_ITER)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Advance the angle and vector registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                r_reg <= r_init;
                m_reg <= MOD_START;
            end
            C_RED:
            begin
                r_reg <= r_red;
                m_reg <= m_reg >> 1;
            end
            C_WRAP:
            begin
                z_reg <= z_wrap;
            end
            C_FLIP:
            begin
                if (z_gt)
                begin
                    z_reg <= z_reg - PI_Z;
                end
                else if (z_lt)
                begin
                    z_reg <= z_reg + PI_Z;
                end
                x_reg <= X_START;
                y_reg <= '0;
            end
            C_ITER:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan;
                end
            end
            C_OUT:
            begin
                trig_reg.cos_q29 <= c_out;
                trig_reg.sin_q29 <= s_out;
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign trig = trig_reg;

endmodule

// ===== hdl/differential_drive_odometry.sv =====
`timescale 1ns / 1ps

// Channel | Interface     | Direction | Payload
// ticks   | ddo_ticks_if  | sink      | left_ticks, right_ticks (32-bit signed)
// pose    | ddo_pose_if   | source    | pos_x, pos_y (48-bit), heading (32-bit)
// cfg     | ddo_cfg_if    | sink      | index (2-bit), data (32-bit, low 24 kept)
//
// One item holds the block for five shared-multiplier steps, the modulo-two-pi
// reduction (31 - FRAC_BITS steps) and CORDIC_ITERATIONS rotations on one adder
// set; these run between the heading product and the x and y products.
// ticks.ready is high only while idle; cfg.ready is always high.
// A finished pose waits in its output register; a new transfer is taken meanwhile.
// Reset restores the register defaults and clears distances and position.

module differential_drive_odometry import ddo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int FRAC_BITS         = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    ddo_ticks_if.sink    ticks,
    ddo_pose_if.source   pose,
    ddo_cfg_if.sink      cfg
);

    localparam int DIST_SH = FACTOR_FRAC - FRAC_BITS;

    localparam logic signed [MUL_P_W-1:0] DIST_RND = (MUL_P_W'(1) << DIST_SH) >>> 1;
    localparam logic signed [MUL_P_W-1:0] HEAD_RND = MUL_P_W'(1) << (IBW_FRAC - 1);
    localparam logic signed [MUL_P_W-1:0] INC_RND  = MUL_P_W'(1) << (INC_SHIFT - 1);
    localparam logic signed [MUL_P_W-1:0] W_MAX    = MUL_P_W'(64'sh7FFFFFFF);
    localparam logic signed [MUL_P_W-1:0] W_MIN    = -W_MAX - 1;
    localparam logic signed [POS_W+1:0]   P_MAX    = (POS_W + 2)'(64'sh7FFFFFFFFFFF);
    localparam logic signed [POS_W+1:0]   P_MIN    = -P_MAX - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ML, S_MR, S_MD, S_MH, S_HD, S_TRIG, S_MX, S_MY, S_YU, S_OUT
    } state_t;

    function automatic logic signed [TICK_W-1:0] sat_word(
        input logic signed [MUL_P_W-1:0] v
    );
        logic signed [TICK_W-1:0] r;
        if (v > W_MAX)
        begin
            r = W_MAX[TICK_W-1:0];
        end
        else if (v < W_MIN)
        begin
            r = W_MIN[TICK_W-1:0];
        end
        else
        begin
            r = v[TICK_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(
        input logic signed [POS_W+1:0] v
    );
        logic signed [POS_W-1:0] r;
        if (v > P_MAX)
        begin
            r = P_MAX[POS_W-1:0];
        end
        else if (v < P_MIN)
        begin
            r = P_MIN[POS_W-1:0];
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   start_reg;

    logic [FACTOR_W-1:0] lmpt_reg;
    logic [FACTOR_W-1:0] rmpt_reg;
    logic [FACTOR_W-1:0] ibw_reg;

    logic signed [TICK_W-1:0] lprev_reg;
    logic signed [TICK_W-1:0] rprev_reg;
    logic signed [POS_W-1:0]  x_reg;
    logic signed [POS_W-1:0]  y_reg;

    logic signed [TICK_W-1:0]  lt_reg;
    logic signed [TICK_W-1:0]  rt_reg;
    logic signed [TICK_W-1:0]  ld_reg;
    logic signed [TICK_W-1:0]  rd_reg;
    logic signed [MUL_A_W-1:0] adv_reg;
    logic signed [HEAD_W-1:0]  hd_reg;
    logic signed [POS_W-1:0]   px_out_reg;
    logic signed [POS_W-1:0]   py_out_reg;
    logic signed [HEAD_W-1:0]  hd_out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [TICK_W-1:0]  dist_calc;
    logic signed [HEAD_W-1:0]  head_calc;
    logic signed [MUL_P_W-1:0] inc_full;
    logic signed [POS_W+1:0]   x_sum;
    logic signed [POS_W+1:0]   y_sum;
    logic                      out_free;
    logic                      trig_done;
    trig_t                     trig;

    ddo_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ddo_cordic
    #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .FRAC_BITS         (FRAC_BITS)
    )
    u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .heading (hd_reg),
        .done    (trig_done),
        .trig    (trig)
    );

    // Select the multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ML:
            begin
                mul_a = MUL_A_W'(lt_reg);
                mul_b = signed'(MUL_B_W'(lmpt_reg));
            end
            S_MR:
            begin
                mul_a = MUL_A_W'(rt_reg);
                mul_b = signed'(MUL_B_W'(rmpt_reg));
            end
            S_MH:
            begin
                mul_a = MUL_A_W'(rd_reg) - MUL_A_W'(ld_reg);
                mul_b = signed'(MUL_B_W'(ibw_reg));
            end
            S_MX:
            begin
                mul_a = adv_reg;
                mul_b = trig.cos_q29;
            end
            S_MY:
            begin
                mul_a = adv_reg;
                mul_b = trig.sin_q29;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round the products and saturate the distance and heading words
    always_comb
    begin
        dist_calc = sat_word((mul_p + DIST_RND) >>> DIST_SH);
        head_calc = sat_word((mul_p + HEAD_RND) >>> IBW_FRAC);
        inc_full  = (mul_p + INC_RND) >>> INC_SHIFT;
        x_sum     = (POS_W + 2)'(x_reg) + (POS_W + 2)'(inc_full);
        y_sum     = (POS_W + 2)'(y_reg) + (POS_W + 2)'(inc_full);
    end

    assign out_free = !out_valid_reg || pose.ready;

    // Sequence one item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (ticks.valid) state_next = S_ML;
            S_ML:   state_next = S_MR;
            S_MR:   state_next = S_MD;
            S_MD:   state_next = S_MH;
            S_MH:   state_next = S_HD;
            S_HD:   state_next = S_TRIG;
            S_TRIG: if (trig_done) state_next = S_MX;
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_YU;
            S_YU:   state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state, configuration and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            lmpt_reg      <= LEFT_MPT_RST;
            rmpt_reg      <= RIGHT_MPT_RST;
            ibw_reg       <= INV_WHEELBASE_RST;
            lprev_reg     <= '0;
            rprev_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == S_HD);

            // Decode configuration writes, drop unknown indexes
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_LEFT_MPT:      lmpt_reg <= cfg.data[FACTOR_W-1:0];
                    REG_RIGHT_MPT:     rmpt_reg <= cfg.data[FACTOR_W-1:0];
                    REG_INV_WHEELBASE: ibw_reg  <= cfg.data[FACTOR_W-1:0];
                    default:           ibw_reg  <= ibw_reg;
                endcase
            end

            if (state_reg == S_MH)
            begin
                lprev_reg <= ld_reg;
                rprev_reg <= rd_reg;
            end
            if (state_reg == S_MY)
            begin
                x_reg <= sat_pos(x_sum);
            end
            if (state_reg == S_YU)
            begin
                y_reg <= sat_pos(y_sum);
            end

            // Output register: load when free, drop after transfer
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pose.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture working values
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && ticks.valid)
        begin
            lt_reg <= ticks.left_ticks;
            rt_reg <= ticks.right_ticks;
        end
        if (state_reg == S_MR)
        begin
            ld_reg <= dist_calc;
        end
        if (state_reg == S_MD)
        begin
            rd_reg <= dist_calc;
        end
        if (state_reg == S_MH)
        begin
            adv_reg <= MUL_A_W'(ld_reg) - MUL_A_W'(lprev_reg)
                     + MUL_A_W'(rd_reg) - MUL_A_W'(rprev_reg);
        end
        if (state_reg == S_HD)
        begin
            hd_reg <= head_calc;
        end
        if (state_reg == S_OUT && out_free)
        begin
            px_out_reg <= x_reg;
            py_out_reg <= y_reg;
            hd_out_reg <= hd_reg;
        end
    end

    assign ticks.ready  = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign pose.valid   = out_valid_reg;
    assign pose.pos_x   = px_out_reg;
    assign pose.pos_y   = py_out_reg;
    assign pose.heading = hd_out_reg;

endmodule

// ===== hdl/ddo_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ddo_checker import ddo_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     ticks_valid,
    input logic                     ticks_ready,
    input logic                     pose_valid,
    input logic                     pose_ready,
    input logic signed [POS_W-1:0]  pose_x,
    input logic signed [POS_W-1:0]  pose_y,
    input logic signed [HEAD_W-1:0] pose_heading
);

    logic ticks_xfer;
    logic pose_stall;

    assign ticks_xfer = ticks_valid && ticks_ready;
    assign pose_stall = pose_valid && !pose_ready;

    // Busy after taking an item
    `ASSERT_NEXT(a_busy_after_xfer, ticks_xfer, !ticks_ready, "ticks ready right after transfer")

    // No result appears on the cycle after an item is taken
    `ASSERT_NEXT(a_no_instant_result, ticks_xfer, !$rose(pose_valid), "result too early")

    // Stalled result stays offered
    `ASSERT_NEXT(a_pose_valid_hold, pose_stall, pose_valid, "pose valid dropped while stalled")

    // Stalled result payload holds
    `ASSERT_NEXT(a_pose_data_hold, pose_stall,
        $stable(pose_x) && $stable(pose_y) && $stable(pose_heading),
        "pose payload changed while stalled")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .ticks_valid  (ticks.valid),
    .ticks_ready  (ticks.ready),
    .pose_valid   (pose.valid),
    .pose_ready   (pose.ready),
    .pose_x       (pose.pos_x),
    .pose_y       (pose.pos_y),
    .pose_heading (pose.heading)
);
